/* rtl/ptw_pkg.sv */
package ptw_pkg;

	localparam int ADDR_BITS = 48;
	localparam int VA_W      = 48;
	localparam int PA_W      = 48;
	localparam int DESC_W    = 64;
	localparam int IDX_W     = 9;
	localparam int QUEUE_DEPTH = 2;

	// Descriptor output-address mask: bits ADDR_BITS-1 down to 12.
	localparam logic [63:0] ADDR_MASK64 = ((64'd1 << ADDR_BITS) - 64'd1) & ~64'hFFF;
	localparam logic [PA_W-1:0] ADDR_MASK = ADDR_MASK64[PA_W-1:0];

	localparam logic [PA_W-1:0] OFF_1G = 48'h0000_3FFF_FFFF;
	localparam logic [PA_W-1:0] OFF_2M = 48'h0000_001F_FFFF;
	localparam logic [PA_W-1:0] OFF_4K = 48'h0000_0000_0FFF;

	localparam int DESC_VALID_BIT = 0;
	localparam int DESC_TABLE_BIT = 1;

	// Input item kinds
	localparam logic KIND_XLATE = 1'b0;
	localparam logic KIND_DESC  = 1'b1;

	// Result kinds
	localparam logic RES_READ = 1'b0;
	localparam logic RES_DONE = 1'b1;

	// Block sizes
	localparam logic [1:0] BLK_4K = 2'd0;
	localparam logic [1:0] BLK_2M = 2'd1;
	localparam logic [1:0] BLK_1G = 2'd2;

	// Table levels
	localparam logic [1:0] LVL_0 = 2'd0;
	localparam logic [1:0] LVL_1 = 2'd1;
	localparam logic [1:0] LVL_2 = 2'd2;
	localparam logic [1:0] LVL_3 = 2'd3;

	// Classified item as it travels from the front to the back.
	// addr holds root_table for a translate request, descriptor[47:0] plus
	// the control bits for a descriptor response.
	typedef struct packed {
		logic            kind;
		logic [PA_W-1:0] addr;
		logic [VA_W-1:0] virt;
	} ptw_item_t;

endpackage

/* rtl/ptw_item_if.sv */
interface ptw_item_if;
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic [ptw_pkg::PA_W-1:0]   root_table;
	logic [ptw_pkg::VA_W-1:0]   vaddr;
	logic [ptw_pkg::DESC_W-1:0] descriptor;

	modport source (output valid, kind, root_table, vaddr, descriptor, input ready);
	modport sink (input valid, kind, root_table, vaddr, descriptor, output ready);
endinterface

/* rtl/ptw_result_if.sv */
interface ptw_result_if;
	logic                     valid;
	logic                     ready;
	logic                     kind_res;
	logic [ptw_pkg::PA_W-1:0] read_addr;
	logic [ptw_pkg::PA_W-1:0] paddr;
	logic                     fault;
	logic [1:0]               block_size;
	logic [1:0]               level_reached;

	modport source (output valid, kind_res, read_addr, paddr, fault, block_size,
		level_reached, input ready);
	modport sink (input valid, kind_res, read_addr, paddr, fault, block_size,
		level_reached, output ready);
endinterface

/* rtl/ptw_front.sv */
module ptw_front (
	input  logic               clk,
	input  logic               arst_n,
	ptw_item_if.sink           item,
	output ptw_pkg::ptw_item_t head,
	output logic               head_valid,
	input  logic               head_pop
);

	localparam int PTR_W = $clog2(ptw_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(ptw_pkg::QUEUE_DEPTH + 1);

	ptw_pkg::ptw_item_t entry_q [ptw_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	ptw_pkg::ptw_item_t classified;
	logic               push;
	logic               pop;

	// Keep only the fields the back end needs for each kind.
	always_comb begin
		classified.kind = item.kind;
		classified.virt = item.vaddr;
		if (item.kind == ptw_pkg::KIND_XLATE) begin
			classified.addr = item.root_table;
		end else begin
			classified.addr = item.descriptor[ptw_pkg::PA_W-1:0];
		end
	end

	assign item.ready = (count_q != CNT_W'(ptw_pkg::QUEUE_DEPTH));
	assign push       = item.valid && item.ready;
	assign head_valid = (count_q != '0);
	assign pop        = head_pop && head_valid;
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= classified;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(ptw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(ptw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/ptw_back.sv */
module ptw_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ptw_pkg::ptw_item_t    head,
	input  logic                  head_valid,
	output logic                  head_pop,
	ptw_result_if.source          result
);

	logic                      busy_q;
	logic [1:0]                walk_level_q;
	logic [ptw_pkg::VA_W-1:0]  saved_virt_q;

	logic                      out_valid_q;
	logic                      kind_res_q;
	logic [ptw_pkg::PA_W-1:0]  read_addr_q;
	logic [ptw_pkg::PA_W-1:0]  paddr_q;
	logic                      fault_q;
	logic [1:0]                block_size_q;
	logic [1:0]                level_reached_q;

	logic                      slot_free;
	logic                      has_res;
	logic                      fire;
	logic                      res_kind;
	logic [ptw_pkg::PA_W-1:0]  res_read;
	logic [ptw_pkg::PA_W-1:0]  res_phys;
	logic                      res_fault;
	logic [1:0]                res_blk;
	logic [1:0]                res_lvl;
	logic                      nxt_busy;
	logic [1:0]                nxt_level;
	logic [ptw_pkg::VA_W-1:0]  nxt_virt;

	logic [ptw_pkg::PA_W-1:0]  base;
	logic [ptw_pkg::PA_W-1:0]  tbl;
	logic [ptw_pkg::VA_W-1:0]  idx_virt;
	logic [1:0]                idx_level;
	logic [ptw_pkg::IDX_W-1:0] idx;
	logic [ptw_pkg::PA_W-1:0]  entry_addr;

	assign base = head.addr & ptw_pkg::ADDR_MASK;

	// Pick the 9-bit table index for the level being looked up.
	always_comb begin
		unique case (idx_level)
			ptw_pkg::LVL_0: idx = idx_virt[47:39];
			ptw_pkg::LVL_1: idx = idx_virt[38:30];
			ptw_pkg::LVL_2: idx = idx_virt[29:21];
			default:        idx = idx_virt[20:12];
		endcase
	end

	assign entry_addr = tbl + {{(ptw_pkg::PA_W - ptw_pkg::IDX_W - 3){1'b0}}, idx, 3'b000};

	always_comb begin
		has_res   = 1'b0;
		res_kind  = ptw_pkg::RES_READ;
		res_read  = '0;
		res_phys  = '0;
		res_fault = 1'b0;
		res_blk   = ptw_pkg::BLK_4K;
		res_lvl   = ptw_pkg::LVL_0;
		nxt_busy  = busy_q;
		nxt_level = walk_level_q;
		nxt_virt  = saved_virt_q;
		tbl       = base;
		idx_virt  = saved_virt_q;
		idx_level = walk_level_q + 1'b1;
		if (head.kind == ptw_pkg::KIND_XLATE) begin
			tbl       = head.addr;
			idx_virt  = head.virt;
			idx_level = ptw_pkg::LVL_0;
			if (!busy_q) begin
				has_res   = 1'b1;
				res_read  = entry_addr;
				nxt_busy  = 1'b1;
				nxt_level = ptw_pkg::LVL_0;
				nxt_virt  = head.virt;
			end
		end else if (busy_q) begin
			has_res = 1'b1;
			if (!head.addr[ptw_pkg::DESC_VALID_BIT]) begin
				res_kind  = ptw_pkg::RES_DONE;
				res_fault = 1'b1;
				res_lvl   = walk_level_q;
				nxt_busy  = 1'b0;
			end else if (walk_level_q == ptw_pkg::LVL_1 && !head.addr[ptw_pkg::DESC_TABLE_BIT]) begin
				res_kind = ptw_pkg::RES_DONE;
				res_phys = base | (saved_virt_q & ptw_pkg::OFF_1G);
				res_blk  = ptw_pkg::BLK_1G;
				res_lvl  = walk_level_q;
				nxt_busy = 1'b0;
			end else if (walk_level_q == ptw_pkg::LVL_2 && !head.addr[ptw_pkg::DESC_TABLE_BIT]) begin
				res_kind = ptw_pkg::RES_DONE;
				res_phys = base | (saved_virt_q & ptw_pkg::OFF_2M);
				res_blk  = ptw_pkg::BLK_2M;
				res_lvl  = walk_level_q;
				nxt_busy = 1'b0;
			end else if (walk_level_q == ptw_pkg::LVL_3) begin
				res_kind = ptw_pkg::RES_DONE;
				res_phys = base | (saved_virt_q & ptw_pkg::OFF_4K);
				res_blk  = ptw_pkg::BLK_4K;
				res_lvl  = walk_level_q;
				nxt_busy = 1'b0;
			end else begin
				res_read  = entry_addr;
				nxt_level = walk_level_q + 1'b1;
			end
		end
	end

	assign slot_free = !out_valid_q || result.ready;
	assign head_pop  = head_valid && (slot_free || !has_res);
	assign fire      = head_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			walk_level_q <= ptw_pkg::LVL_0;
			saved_virt_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (fire) begin
				busy_q       <= nxt_busy;
				walk_level_q <= nxt_level;
				saved_virt_q <= nxt_virt;
			end
			if (fire && has_res) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_res) begin
			kind_res_q      <= res_kind;
			read_addr_q     <= res_read;
			paddr_q         <= res_phys;
			fault_q         <= res_fault;
			block_size_q    <= res_blk;
			level_reached_q <= res_lvl;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.kind_res      = kind_res_q;
	assign result.read_addr     = read_addr_q;
	assign result.paddr         = paddr_q;
	assign result.fault         = fault_q;
	assign result.block_size    = block_size_q;
	assign result.level_reached = level_reached_q;

endmodule

/* rtl/page_table_walker_top.sv */
// An accepted transaction is written into the queue; the output register holds its result.
// Throughput: one transaction per cycle unless results stall; a two-entry queue and an
// output register decouple both sides; the descriptor step (a 48-bit add) sets cycle time.
// Reset (arst_n low, asynchronous): walker idle at level 0, queue and output emptied.
module page_table_walker_top (
	input  logic          clk,
	input  logic          arst_n,
	ptw_item_if.sink      item,
	ptw_result_if.source  result
);

	// Queue head travelling from the intake side to the walk engine
	ptw_pkg::ptw_item_t     head;
	logic                   head_valid;
	logic                   head_pop;

	// Front: accept every transaction, strip it to the fields its kind uses, queue it
	ptw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop)
	);

	// Back: hold the walk state, drop stray transactions, advance one level per descriptor
	ptw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.result     (result)
	);

endmodule

/* dv/page_table_walker_top_tb.sv */
`timescale 1ns / 100ps

module page_table_walker_top_tb;

	// One input transaction as the walker sees it.
	typedef struct packed {
		logic                       kind;
		logic [ptw_pkg::PA_W-1:0]   root_table;
		logic [ptw_pkg::VA_W-1:0]   vaddr;
		logic [ptw_pkg::DESC_W-1:0] descriptor;
	} walk_req_t;

	// One result transaction: either a descriptor read or a finished walk.
	typedef struct packed {
		logic                     kind_res;
		logic [ptw_pkg::PA_W-1:0] read_addr;
		logic [ptw_pkg::PA_W-1:0] paddr;
		logic                     fault;
		logic [1:0]               block_size;
		logic [1:0]               level_reached;
	} walk_res_t;

	// How a directed row gets its expectation: from the walk predictor, typed
	// in by hand, or none at all (the block must drop the transaction).
	typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_SILENT} row_mode_e;

	typedef struct packed {
		row_mode_e mode;
		walk_req_t req;
		walk_res_t res;
	} dir_row_t;

	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n;

	ptw_item_if   item ();
	ptw_result_if result ();

	page_table_walker_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result)
	);

	always #5 clk = ~clk;

	// Shadow walker state, advanced once per accepted input transaction.
	bit                       walk_busy;
	logic [1:0]               walk_lvl;
	logic [ptw_pkg::VA_W-1:0] walk_va;

	walk_res_t due_walk_results[$];
	dir_row_t  dir_rows[$];

	int n_errors;
	int n_sent;
	int cycle_count;
	int send_idle_pct;
	int recv_idle_pct;

	// ------------------------------------------------------------------
	// Walk predictor
	// ------------------------------------------------------------------

	// Address of the entry for the current level: table + 9-bit index * 8,
	// wrapped to the physical width.
	function automatic logic [ptw_pkg::PA_W-1:0] entry_addr(
		input logic [ptw_pkg::PA_W-1:0] tbl, input logic [1:0] lvl);
		logic [ptw_pkg::VA_W-1:0]  shifted;
		logic [ptw_pkg::IDX_W-1:0] idx;
		shifted = walk_va >> (39 - 9 * int'(lvl));
		idx = shifted[ptw_pkg::IDX_W-1:0];
		return tbl + {{(ptw_pkg::PA_W - ptw_pkg::IDX_W - 3){1'b0}}, idx, 3'b000};
	endfunction

	// Advance the shadow walker by one transaction; return 1 when a result
	// follows, with that result in rs.
	function automatic bit predict_walk(input walk_req_t rq, output walk_res_t rs);
		logic [ptw_pkg::PA_W-1:0] base;
		rs = '0;
		if (rq.kind == ptw_pkg::KIND_XLATE) begin
			// A new request while a walk is open is dropped.
			if (walk_busy)
				return 1'b0;
			walk_busy = 1'b1;
			walk_lvl = ptw_pkg::LVL_0;
			walk_va = rq.vaddr;
			rs.kind_res = ptw_pkg::RES_READ;
			rs.read_addr = entry_addr(rq.root_table, ptw_pkg::LVL_0);
			return 1'b1;
		end
		// A descriptor with no walk open is dropped.
		if (!walk_busy)
			return 1'b0;
		base = rq.descriptor[ptw_pkg::PA_W-1:0] & ptw_pkg::ADDR_MASK;
		rs.kind_res = ptw_pkg::RES_DONE;
		rs.level_reached = walk_lvl;
		if (!rq.descriptor[ptw_pkg::DESC_VALID_BIT]) begin
			walk_busy = 1'b0;
			rs.fault = 1'b1;
		end else if (walk_lvl == ptw_pkg::LVL_1 && !rq.descriptor[ptw_pkg::DESC_TABLE_BIT]) begin
			walk_busy = 1'b0;
			rs.paddr = base | (walk_va & ptw_pkg::OFF_1G);
			rs.block_size = ptw_pkg::BLK_1G;
		end else if (walk_lvl == ptw_pkg::LVL_2 && !rq.descriptor[ptw_pkg::DESC_TABLE_BIT]) begin
			walk_busy = 1'b0;
			rs.paddr = base | (walk_va & ptw_pkg::OFF_2M);
			rs.block_size = ptw_pkg::BLK_2M;
		end else if (walk_lvl == ptw_pkg::LVL_3) begin
			// The page bit is not looked at on the last level.
			walk_busy = 1'b0;
			rs.paddr = base | (walk_va & ptw_pkg::OFF_4K);
			rs.block_size = ptw_pkg::BLK_4K;
		end else begin
			// Level 0 always descends, whatever its table bit says.
			walk_lvl = walk_lvl + 2'd1;
			rs = '0;
			rs.kind_res = ptw_pkg::RES_READ;
			rs.read_addr = entry_addr(base, walk_lvl);
		end
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Helpers for the directed table
	// ------------------------------------------------------------------

	function automatic walk_res_t read_req(input logic [ptw_pkg::PA_W-1:0] addr);
		walk_res_t rs;
		rs = '0;
		rs.kind_res = ptw_pkg::RES_READ;
		rs.read_addr = addr;
		return rs;
	endfunction

	function automatic walk_res_t walk_done(input logic [ptw_pkg::PA_W-1:0] pa,
		input logic flt, input logic [1:0] bs, input logic [1:0] lv);
		walk_res_t rs;
		rs = '0;
		rs.kind_res = ptw_pkg::RES_DONE;
		rs.paddr = pa;
		rs.fault = flt;
		rs.block_size = bs;
		rs.level_reached = lv;
		return rs;
	endfunction

	function automatic dir_row_t mk_row(input row_mode_e mode, input logic kind,
		input logic [ptw_pkg::PA_W-1:0] root, input logic [ptw_pkg::VA_W-1:0] va,
		input logic [ptw_pkg::DESC_W-1:0] desc, input walk_res_t res = '0);
		dir_row_t r;
		r.mode = mode;
		r.req.kind = kind;
		r.req.root_table = root;
		r.req.vaddr = va;
		r.req.descriptor = desc;
		r.res = res;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Random values
	// ------------------------------------------------------------------

	// Lean on the all-zero and all-one corners now and then.
	function automatic logic [ptw_pkg::PA_W-1:0] rand_addr();
		int pick;
		logic [63:0] raw;
		pick = $urandom_range(19);
		raw = {$urandom, $urandom};
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return raw[ptw_pkg::PA_W-1:0];
	endfunction

	function automatic logic [ptw_pkg::DESC_W-1:0] rand_desc();
		return {$urandom, $urandom};
	endfunction

	// ------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------

	// Drive one transaction, hold it until accepted, and record what the
	// block owes for it. Entered and left at a rising edge.
	task automatic send_item(input walk_req_t rq, input row_mode_e mode = ROW_PREDICT,
		input walk_res_t typed_res = '0);
		walk_res_t rs;
		bit has_res;
		while ($urandom_range(99) < send_idle_pct) begin
			item.valid <= 1'b0;
			@(posedge clk);
		end
		item.valid <= 1'b1;
		item.kind <= rq.kind;
		item.root_table <= rq.root_table;
		item.vaddr <= rq.vaddr;
		item.descriptor <= rq.descriptor;
		// Sample the handshake mid-cycle, where it is settled; the transaction
		// goes through at the following rising edge.
		@(negedge clk);
		while (!item.ready)
			@(negedge clk);
		has_res = predict_walk(rq, rs);
		if (mode == ROW_SILENT)
			has_res = 1'b0;
		else if (mode == ROW_TYPED) begin
			has_res = 1'b1;
			rs = typed_res;
		end
		if (has_res)
			due_walk_results.push_back(rs);
		n_sent++;
		@(posedge clk);
	endtask

	// Drop valid and hold off until the block has delivered every result.
	task automatic drain_results();
		item.valid <= 1'b0;
		@(posedge clk);
		while (due_walk_results.size() != 0)
			@(posedge clk);
	endtask

	// One well-formed walk with random content, with stray transactions
	// mixed in: descriptors while idle and requests while a walk is open.
	task automatic random_walk();
		walk_req_t rq;
		rq.root_table = rand_addr();
		rq.vaddr = rand_addr();
		rq.descriptor = rand_desc();
		if ($urandom_range(99) < 8) begin
			rq.kind = ptw_pkg::KIND_DESC;
			send_item(rq);
		end
		rq.kind = ptw_pkg::KIND_XLATE;
		send_item(rq);
		while (walk_busy) begin
			if ($urandom_range(99) < 6) begin
				rq.kind = ptw_pkg::KIND_XLATE;
				rq.root_table = rand_addr();
				rq.vaddr = rand_addr();
				send_item(rq);
			end
			rq.kind = ptw_pkg::KIND_DESC;
			rq.descriptor = rand_desc();
			rq.descriptor[ptw_pkg::DESC_VALID_BIT] = $urandom_range(99) >= 8;
			// Make blocks common on the levels that allow them.
			if (walk_lvl == ptw_pkg::LVL_1 || walk_lvl == ptw_pkg::LVL_2)
				rq.descriptor[ptw_pkg::DESC_TABLE_BIT] = $urandom_range(99) >= 35;
			send_item(rq);
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver and checker
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		n_errors++;
		$display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
	endtask

	// Stall the result side at random at every edge.
	always @(posedge clk)
		result.ready <= $urandom_range(99) >= recv_idle_pct;

	// Compare each result transaction, field by field, with the oldest one due.
	always @(negedge clk) begin
		walk_res_t got;
		walk_res_t want;
		if (arst_n && result.valid && result.ready) begin
			got.kind_res = result.kind_res;
			got.read_addr = result.read_addr;
			got.paddr = result.paddr;
			got.fault = result.fault;
			got.block_size = result.block_size;
			got.level_reached = result.level_reached;
			if (due_walk_results.size() == 0)
				report_mismatch("result with none due, read_addr", 64'(got.read_addr), '0);
			else begin
				want = due_walk_results.pop_front();
				if (got.kind_res !== want.kind_res)
					report_mismatch("kind_res", 64'(got.kind_res), 64'(want.kind_res));
				if (got.read_addr !== want.read_addr)
					report_mismatch("read_addr", 64'(got.read_addr), 64'(want.read_addr));
				if (got.paddr !== want.paddr)
					report_mismatch("paddr", 64'(got.paddr), 64'(want.paddr));
				if (got.fault !== want.fault)
					report_mismatch("fault", 64'(got.fault), 64'(want.fault));
				if (got.block_size !== want.block_size)
					report_mismatch("block_size", 64'(got.block_size),
						64'(want.block_size));
				if (got.level_reached !== want.level_reached)
					report_mismatch("level_reached", 64'(got.level_reached),
						64'(want.level_reached));
			end
		end
	end

	// Stop a hung run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("page_table_walker_top_tb: done, errors");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		item.valid = 1'b0;
		item.kind = ptw_pkg::KIND_XLATE;
		item.root_table = '0;
		item.vaddr = '0;
		item.descriptor = '0;
		result.ready = 1'b0;
		walk_busy = 1'b0;
		walk_lvl = ptw_pkg::LVL_0;
		walk_va = '0;
		n_errors = 0;
		n_sent = 0;
		send_idle_pct = 18;
		recv_idle_pct = 77;

		// Directed table: corners, every outcome, and each dropped case.
		// Stray descriptor right after reset: dropped.
		dir_rows.push_back(mk_row(ROW_SILENT, ptw_pkg::KIND_DESC, '0, '0, '1));
		dir_rows.push_back(mk_row(ROW_TYPED, ptw_pkg::KIND_XLATE, '0, '0, '0, read_req('0)));
		// Request while a walk is open: dropped.
		dir_rows.push_back(mk_row(ROW_SILENT, ptw_pkg::KIND_XLATE, '1, '1, '0));
		dir_rows.push_back(mk_row(ROW_TYPED, ptw_pkg::KIND_DESC, '0, '0, '0,
			walk_done('0, 1'b1, ptw_pkg::BLK_4K, ptw_pkg::LVL_0)));
		// All-ones table and address: the entry address wraps.
		dir_rows.push_back(mk_row(ROW_TYPED, ptw_pkg::KIND_XLATE, '1, '1, '0,
			read_req(48'h0000_0000_0FF7)));
		dir_rows.push_back(mk_row(ROW_PREDICT, ptw_pkg::KIND_DESC, '0, '0, '1));
		dir_rows.push_back(mk_row(ROW_TYPED, ptw_pkg::KIND_DESC, '0, '0,
			64'hFFFF_FFFF_FFFF_FFFD, walk_done('1, 1'b0, ptw_pkg::BLK_1G, ptw_pkg::LVL_1)));
		// Level 0 entry with its table bit clear still descends; 2 MB block.
		dir_rows.push_back(mk_row(ROW_PREDICT, ptw_pkg::KIND_XLATE, 48'h0000_1234_5000,
			48'h0000_4020_1ABC, '0));
		dir_rows.push_back(mk_row(ROW_PREDICT, ptw_pkg::KIND_DESC, '0, '0,
			64'h0000_0000_8000_0001));
		dir_rows.push_back(mk_row(ROW_PREDICT, ptw_pkg::KIND_DESC, '0, '0,
			64'h0000_0000_9000_0003));
		dir_rows.push_back(mk_row(ROW_PREDICT, ptw_pkg::KIND_DESC, '0, '0,
			64'h0000_0000_A020_0001));
		// Full four-level walk; the last entry has its page bit clear.
		dir_rows.push_back(mk_row(ROW_PREDICT, ptw_pkg::KIND_XLATE, 48'hABCD_EF01_2000,
			48'h8765_4321_0FED, '0));
		dir_rows.push_back(mk_row(ROW_PREDICT, ptw_pkg::KIND_DESC, '0, '0,
			64'hFFFF_0000_0001_0003));
		dir_rows.push_back(mk_row(ROW_PREDICT, ptw_pkg::KIND_DESC, '0, '0,
			64'h0000_0000_0002_0003));
		dir_rows.push_back(mk_row(ROW_PREDICT, ptw_pkg::KIND_DESC, '0, '0,
			64'h0000_0000_0003_0003));
		dir_rows.push_back(mk_row(ROW_PREDICT, ptw_pkg::KIND_DESC, '0, '0,
			64'h8000_7FFF_FFFF_F001));
		// Fault on level 2.
		dir_rows.push_back(mk_row(ROW_TYPED, ptw_pkg::KIND_XLATE, '0, '0, '0, read_req('0)));
		dir_rows.push_back(mk_row(ROW_PREDICT, ptw_pkg::KIND_DESC, '0, '0, 64'h3));
		dir_rows.push_back(mk_row(ROW_PREDICT, ptw_pkg::KIND_DESC, '0, '0, 64'h3));
		dir_rows.push_back(mk_row(ROW_TYPED, ptw_pkg::KIND_DESC, '0, '0, '0,
			walk_done('0, 1'b1, ptw_pkg::BLK_4K, ptw_pkg::LVL_2)));
		// Fault on level 3, from an entry with every other bit set.
		dir_rows.push_back(mk_row(ROW_TYPED, ptw_pkg::KIND_XLATE, '0, '0, '0, read_req('0)));
		dir_rows.push_back(mk_row(ROW_PREDICT, ptw_pkg::KIND_DESC, '0, '0, 64'h3));
		dir_rows.push_back(mk_row(ROW_PREDICT, ptw_pkg::KIND_DESC, '0, '0, 64'h3));
		dir_rows.push_back(mk_row(ROW_PREDICT, ptw_pkg::KIND_DESC, '0, '0, 64'h3));
		dir_rows.push_back(mk_row(ROW_TYPED, ptw_pkg::KIND_DESC, '0, '0,
			64'hFFFF_FFFF_FFFF_FFFE, walk_done('0, 1'b1, ptw_pkg::BLK_4K, ptw_pkg::LVL_3)));
		dir_rows.push_back(mk_row(ROW_SILENT, ptw_pkg::KIND_DESC, '0, '0, '0));

		// Hold reset, then release it at an edge.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].req, dir_rows[i].mode, dir_rows[i].res);

		// Hold off until the directed results are all in.
		drain_results();

		// Slow sender, slower receiver.
		while (n_sent < 230)
			random_walk();
		drain_results();

		// Swap: the sender idles most, the receiver rarely.
		send_idle_pct = 77;
		recv_idle_pct = 18;
		while (n_sent < 440)
			random_walk();
		drain_results();

		// Full rate both ways.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (n_sent < 650)
			random_walk();
		drain_results();

		// Let any stray extra result show up before the verdict.
		repeat (10) @(posedge clk);
		if (n_errors == 0)
			$display("page_table_walker_top_tb: done, clean");
		else
			$display("page_table_walker_top_tb: done, errors");
		$finish;
	end

endmodule
